@@ sv/sqt_pkg.sv @@
// ----------------------------------------------------------------------------
// sqt_pkg: shared types and helpers for the grid square walk
// Widths of the move fields, the square record passed from the walker to the
// output stage, and the step magnitude helper.
// ----------------------------------------------------------------------------
package sqt_pkg;

  localparam int START_W = 8;   // start square coordinate
  localparam int DELTA_W = 5;   // signed displacement
  localparam int MAG_W   = 4;   // displacement magnitude, 0..MAX_STEP
  localparam int COORD_W = 10;  // two's complement square coordinate
  localparam int ACC_W   = 11;  // signed walk accumulator
  localparam int BND_W   = 10;  // column bound

  localparam logic [MAG_W-1:0] MAX_STEP = 4'd15;

  // one touched square from the walker
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } sq_t;

  // magnitude of a displacement, saturated to MAX_STEP
  function automatic logic [MAG_W-1:0] step_mag(input logic signed [DELTA_W-1:0] d);
    logic [DELTA_W-1:0] m;
    m = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
    if (m > DELTA_W'(MAX_STEP)) begin
      return MAX_STEP;
    end
    return m[MAG_W-1:0];
  endfunction

endpackage

@@ sv/sqt_walk.sv @@
// ----------------------------------------------------------------------------
// sqt_walk: column-by-column supercover walker
// Folds the move into the first quadrant and walks it one square per cycle.
// A single add-and-compare unit decides each step: climb the current column
// or move to the next one, dropping back one row on an exact corner hit.
// ----------------------------------------------------------------------------
module sqt_walk (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sqt_pkg::START_W-1:0]         start_x,
  input  logic [sqt_pkg::START_W-1:0]         start_y,
  input  logic signed [sqt_pkg::DELTA_W-1:0]  delta_x,
  input  logic signed [sqt_pkg::DELTA_W-1:0]  delta_y,
  output logic                                busy,
  output sqt_pkg::sq_t                        sq
);
  import sqt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                      state;
  logic [START_W-1:0]        org_x;
  logic [START_W-1:0]        org_y;
  logic                      neg_x;
  logic                      neg_y;
  logic [MAG_W-1:0]          ax;
  logic [MAG_W-1:0]          ay;
  logic [MAG_W-1:0]          col;
  logic [MAG_W-1:0]          row;
  logic signed [ACC_W-1:0]   acc;    // ax * (2*row - 1)
  logic signed [ACC_W-1:0]   bnd;    // ay * (2*col + 1)

  logic                      accept;
  logic                      final_col;
  logic                      last_sq;
  logic signed [ACC_W-1:0]   two_ax;
  logic signed [ACC_W-1:0]   two_ay;
  logic signed [ACC_W-1:0]   acc_up;
  logic                      climb;
  logic                      corner;
  logic signed [COORD_W-1:0] off_x;
  logic signed [COORD_W-1:0] off_y;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_WALK);
  assign final_col = (col == ax);
  assign last_sq   = final_col && (row == ay);
  assign two_ax    = ACC_W'({ax, 1'b0});
  assign two_ay    = ACC_W'({ay, 1'b0});

  // shared step unit: next row still inside this column's band?
  assign acc_up = acc + two_ax;
  assign climb  = (acc_up <= bnd);
  assign corner = (acc == bnd);

  // unfold the square back into the move's quadrant
  assign off_x = neg_x ? -COORD_W'(col) : COORD_W'(col);
  assign off_y = neg_y ? -COORD_W'(row) : COORD_W'(row);

  always_comb begin
    sq.valid = busy;
    sq.x     = COORD_W'(org_x) + off_x;
    sq.y     = COORD_W'(org_y) + off_y;
    sq.last  = last_sq;
  end

  // sequencer: load a request, then advance one square per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= ST_WALK;
    end else if (busy && last_sq) begin
      state <= ST_IDLE;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      org_x <= start_x;
      org_y <= start_y;
      neg_x <= delta_x[DELTA_W-1];
      neg_y <= delta_y[DELTA_W-1];
      ax    <= step_mag(delta_x);
      ay    <= step_mag(delta_y);
      col   <= '0;
      row   <= '0;
      acc   <= -ACC_W'(step_mag(delta_x));
      bnd   <= ACC_W'(step_mag(delta_y));
    end else if (busy) begin
      if (final_col) begin
        row <= row + 1'b1;
      end else if (climb) begin
        row <= row + 1'b1;
        acc <= acc_up;
      end else begin
        col <= col + 1'b1;
        bnd <= bnd + two_ay;
        if (corner) begin
          row <= row - 1'b1;
          acc <= acc - two_ax;
        end
      end
    end
  end

endmodule

@@ sv/grid_squares_touched_by_segment.sv @@
// ----------------------------------------------------------------------------
// grid_squares_touched_by_segment: supercover squares of one grid move
// Emits every square the center-to-center segment of a move touches, start
// square first, end square last and flagged.
//
//   channel   signals                                   direction
//   request   start, busy, start_x, start_y,            in (busy out)
//             delta_x, delta_y
//   result    strobe, square_x, square_y, last          out
//
// A request is taken when start is high and busy is low. The walker emits
// one square per cycle, each step decided by the single step unit in
// sqt_walk, and takes no new request until the move's last square. Results
// appear in the cycle after the walker produces them, through an output
// register, and busy drops as the last square enters it. There is no stall
// from the result side. Reset clears the sequencer and the strobe.
// ----------------------------------------------------------------------------
module grid_squares_touched_by_segment (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sqt_pkg::START_W-1:0]         start_x,
  input  logic [sqt_pkg::START_W-1:0]         start_y,
  input  logic signed [sqt_pkg::DELTA_W-1:0]  delta_x,
  input  logic signed [sqt_pkg::DELTA_W-1:0]  delta_y,
  output logic                                strobe,
  output logic signed [sqt_pkg::COORD_W-1:0]  square_x,
  output logic signed [sqt_pkg::COORD_W-1:0]  square_y,
  output logic                                last
);
  import sqt_pkg::*;

  sq_t walk_sq;

  sqt_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .start_x (start_x),
    .start_y (start_y),
    .delta_x (delta_x),
    .delta_y (delta_y),
    .busy    (busy),
    .sq      (walk_sq)
  );

  // output register: strobe for one cycle per square
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= walk_sq.valid;
    end
  end

  always_ff @(posedge clk) begin
    square_x <= walk_sq.x;
    square_y <= walk_sq.y;
    last     <= walk_sq.last;
  end

endmodule

@@ sv/sqt_checker.sv @@
// ----------------------------------------------------------------------------
// sqt_checker: port-level checks for the grid square walk
// Watches the request and result ports for sequencing slips.
// ----------------------------------------------------------------------------
module sqt_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                strobe,
  input  logic                                last
);

  // an accepted request holds busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  // the first square follows the cycle after busy rises
  a_first_square: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |=> strobe)
    else $error("no square after request start");

  // squares of one move come back to back
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a move's squares");

  // a non-final square means the walk is still running
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("busy dropped before final square");

  // the final square is never directly followed by another
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("square right after final square");

endmodule

bind grid_squares_touched_by_segment sqt_checker u_sqt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last)
);
